@@ hw/rtl/qse_pkg.sv @@
// qse_pkg: types and constants shared by the quicksort engine and its sort cells.
// No dependencies.
`default_nettype none

package qse_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ELEM_W   = 32;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [CNT_W-1:0]         count_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SETTLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/quicksort_engine.sv @@
// quicksort_engine: top level; load control, settle timer and emit control around
// a chain of CAPACITY sort cells. Depends on qse_pkg and qse_cell.
`default_nettype none

// Elements load at one per cycle; each enters the head cell and ripples down the
// chain of CAPACITY cells, one hop per cycle, so the set stays in ascending order.
// The request marked last ends loading; the block then waits in the settle state
// for the last element to reach its place, and emits the set from the head cell at
// one request per cycle while m_tready is high, the final one marked by m_tlast.
// No new request is taken until the burst has gone out. Requests beyond
// CAPACITY are dropped and m_tuser is raised on every result of that set.
module quicksort_engine (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,  // [31:0] element
	input  wire         s_tlast,  // final_element
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,  // [31:0] sorted_value
	output logic        m_tlast,  // end_of_set
	output logic        m_tuser   // [0] overflowed
);
	import qse_pkg::*;

	state_t     state_q, state_d;
	count_t     count_q, count_d;
	count_t     settle_q, settle_d;
	logic       overflow_q, overflow_d;
	logic       s_fire, m_fire, inject;
	cell_ctrl_t ctrl;

	logic  held_valid [CAPACITY];
	elem_t held_value [CAPACITY];
	logic  pass_valid [CAPACITY];
	elem_t pass_value [CAPACITY];

	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;
	assign inject = s_fire && (count_q < count_t'(CAPACITY));

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic  in_valid_w;
		elem_t in_value_w;
		logic  right_valid_w;
		elem_t right_value_w;

		if (i == 0) begin : g_head
			assign in_valid_w = inject;
			assign in_value_w = elem_t'(s_tdata);
		end else begin : g_body
			assign in_valid_w = pass_valid[i-1];
			assign in_value_w = pass_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_valid_w = 1'b0;
			assign right_value_w = '0;
		end else begin : g_inner
			assign right_valid_w = held_valid[i+1];
			assign right_value_w = held_value[i+1];
		end

		qse_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.in_valid    (in_valid_w),
			.in_value    (in_value_w),
			.right_valid (right_valid_w),
			.right_value (right_value_w),
			.held_valid  (held_valid[i]),
			.held_value  (held_value[i]),
			.pass_valid  (pass_valid[i]),
			.pass_value  (pass_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			settle_q   <= '0;
			overflow_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			settle_q   <= settle_d;
			overflow_q <= overflow_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		settle_d   = settle_q;
		overflow_d = overflow_q;
		ctrl.clear = 1'b0;
		ctrl.shift = 1'b0;
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_fire) begin
					if (inject) begin
						count_d = count_q + count_t'(1);
					end else begin
						overflow_d = 1'b1;
					end
					if (s_tlast) begin
						settle_d = '0;
						state_d  = ST_SETTLE;
					end
				end
			end
			ST_SETTLE: begin
				settle_d = settle_q + count_t'(1);
				if (settle_q == count_t'(CAPACITY - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				m_tvalid = held_valid[0];
				if (m_fire) begin
					ctrl.shift = 1'b1;
					count_d    = count_q - count_t'(1);
					if (count_q == count_t'(1)) begin
						ctrl.clear = 1'b1;
						overflow_d = 1'b0;
						state_d    = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign m_tdata = 32'(held_value[0]);
	assign m_tlast = (count_q == count_t'(1));
	assign m_tuser = overflow_q;

endmodule

`default_nettype wire

@@ hw/rtl/qse_cell.sv @@
// qse_cell: one position of the insertion sorting chain; keeps the smaller value,
// hands the larger one to the next cell, and shifts toward the head while emitting.
// Depends on qse_pkg.
`default_nettype none

module qse_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  qse_pkg::cell_ctrl_t ctrl,
	input  wire                 in_valid,
	input  qse_pkg::elem_t      in_value,
	input  wire                 right_valid,
	input  qse_pkg::elem_t      right_value,
	output logic                held_valid,
	output qse_pkg::elem_t      held_value,
	output logic                pass_valid,
	output qse_pkg::elem_t      pass_value
);
	import qse_pkg::*;

	logic  held_valid_q;
	elem_t held_value_q;
	logic  pass_valid_q;
	elem_t pass_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			pass_valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			held_valid_q <= 1'b0;
			pass_valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			held_valid_q <= right_valid;
			pass_valid_q <= 1'b0;
		end else if (in_valid) begin
			held_valid_q <= 1'b1;
			pass_valid_q <= held_valid_q;
		end else begin
			pass_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			held_value_q <= right_value;
		end else if (in_valid) begin
			if (!held_valid_q) begin
				held_value_q <= in_value;
			end else if (in_value < held_value_q) begin
				held_value_q <= in_value;
				pass_value_q <= held_value_q;
			end else begin
				pass_value_q <= in_value;
			end
		end
	end

	assign held_valid = held_valid_q;
	assign held_value = held_value_q;
	assign pass_valid = pass_valid_q;
	assign pass_value = pass_value_q;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// tb: self-checking bench for quicksort_engine; drives sets of signed elements and checks
// each sorted burst against a local sorting model or a pinned result. Depends on qse_pkg.
`default_nettype none

module tb;
	import qse_pkg::*;

	localparam int RANDOM_REQUESTS = 285;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int TAIL_CYCLES     = 2 * CAPACITY + 8;
	localparam int DIRECTED_ROWS   = 25;

	typedef struct packed {
		elem_t value;
		logic  last;
		logic  ovf;
	} sorted_item_t;

	typedef struct packed {
		elem_t        value;
		logic         last;
		logic         pinned;
		sorted_item_t pin;
	} stim_row_t;

	typedef enum {FILL_ANY, FILL_NARROW, FILL_EDGE, FILL_RISING, FILL_FALLING} fill_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	elem_t        set_store [CAPACITY];
	int           set_count;
	logic         set_dropped;
	sorted_item_t sorted_expected [$];
	sorted_item_t pinned_result;
	logic         pinned_armed;
	logic         quiet;
	int           stall_left;
	int           idle_cycles;
	int           errors;
	int           requests_in;
	int           results_out;
	int           sets_closed;
	int           overflow_sets;
	stim_row_t    directed [DIRECTED_ROWS];

	quicksort_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic elem_t pick_element(input fill_t fill, input int k);
		case (fill)
			FILL_NARROW: return elem_t'($urandom_range(0, 8) - 4);
			FILL_EDGE: begin
				case ($urandom_range(0, 4))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'h00000000;
					3: return 32'hffffffff;
					default: return 32'h00000001;
				endcase
			end
			FILL_RISING: return elem_t'(k * 977) - 32'sd7000;
			FILL_FALLING: return 32'sd7000 - elem_t'(k * 977);
			default: return elem_t'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic sort_model_accept(input elem_t v, input logic last);
		elem_t        key;
		int           j;
		sorted_item_t r;
		if (set_count < CAPACITY) begin
			set_store[set_count] = v;
			set_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (!last) return;
		for (int i = 1; i < set_count; i++) begin
			key = set_store[i];
			j = i - 1;
			while (j >= 0 && set_store[j] > key) begin
				set_store[j + 1] = set_store[j];
				j--;
			end
			set_store[j + 1] = key;
		end
		if (pinned_armed) begin
			sorted_expected.push_back(pinned_result);
			pinned_armed = 1'b0;
		end else begin
			for (int k = 0; k < set_count; k++) begin
				r.value = set_store[k];
				r.last  = (k == set_count - 1);
				r.ovf   = set_dropped;
				sorted_expected.push_back(r);
			end
		end
		sets_closed++;
		if (set_dropped) overflow_sets++;
		set_count   = 0;
		set_dropped = 1'b0;
	endtask

	// hold each request until taken; lower valid only ahead of a gap
	task automatic send_request(input elem_t v, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sorted_expected.size() != 0) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			stall_left = pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		sorted_item_t want;
		logic         moved;
		moved = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				requests_in++;
				sort_model_accept(elem_t'(s_tdata), s_tlast);
			end
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				results_out++;
				if (sorted_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", m_tdata));
				end else begin
					want = sorted_expected.pop_front();
					if (m_tdata !== want.value)
						report_mismatch($sformatf("sorted_value %h, want %h",
							m_tdata, want.value));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("end_of_set %b, want %b",
							m_tlast, want.last));
					if (m_tuser !== want.ovf)
						report_mismatch($sformatf("overflowed %b, want %b",
							m_tuser, want.ovf));
				end
			end
			if (moved) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int    set_len;
		int    random_sent;
		fill_t fill;
		set_count     = 0;
		set_dropped   = 1'b0;
		pinned_armed  = 1'b0;
		quiet         = 1'b0;
		stall_left    = 0;
		idle_cycles   = 0;
		errors        = 0;
		requests_in   = 0;
		results_out   = 0;
		sets_closed   = 0;
		overflow_sets = 0;
		random_sent   = 0;
		directed = '{
			'{32'h7fffffff, 1'b1, 1'b1, '{32'h7fffffff, 1'b1, 1'b0}},
			'{32'h80000000, 1'b1, 1'b1, '{32'h80000000, 1'b1, 1'b0}},
			'{32'hffffffff, 1'b1, 1'b1, '{32'hffffffff, 1'b1, 1'b0}},
			'{32'h7fffffff, 1'b0, 1'b0, '0},
			'{32'h80000000, 1'b0, 1'b0, '0},
			'{32'hffffffff, 1'b0, 1'b0, '0},
			'{32'h00000001, 1'b0, 1'b0, '0},
			'{32'h00000000, 1'b1, 1'b0, '0},
			'{32'h0000000a, 1'b0, 1'b0, '0},
			'{32'hfffffff6, 1'b0, 1'b0, '0},
			'{32'h7fffffff, 1'b0, 1'b0, '0},
			'{32'h80000000, 1'b0, 1'b0, '0},
			'{32'h0000000a, 1'b0, 1'b0, '0},
			'{32'h00000000, 1'b0, 1'b0, '0},
			'{32'h7ffffffe, 1'b0, 1'b0, '0},
			'{32'h80000001, 1'b0, 1'b0, '0},
			'{32'h0000000a, 1'b0, 1'b0, '0},
			'{32'hffffffff, 1'b0, 1'b0, '0},
			'{32'h00000001, 1'b0, 1'b0, '0},
			'{32'h12345678, 1'b0, 1'b0, '0},
			'{32'hedcba988, 1'b0, 1'b0, '0},
			'{32'h00000000, 1'b0, 1'b0, '0},
			'{32'hfffffff6, 1'b0, 1'b0, '0},
			'{32'h55555555, 1'b0, 1'b0, '0},
			'{32'haaaaaaaa, 1'b1, 1'b0, '0}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed[i].pinned) begin
				pinned_result = directed[i].pin;
				pinned_armed  = 1'b1;
			end
			send_request(directed[i].value, directed[i].last);
		end
		wait_drained();

		while (random_sent < RANDOM_REQUESTS) begin
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(CAPACITY + 1, CAPACITY + 4)
				: $urandom_range(1, CAPACITY);
			fill  = fill_t'($urandom_range(0, 4));
			quiet = ($urandom_range(0, 7) == 0);
			for (int k = 0; k < set_len; k++)
				send_request(pick_element(fill, k), k == set_len - 1);
			random_sent += set_len;
			if ($urandom_range(0, 9) == 0) wait_drained();
		end
		quiet = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d sets (%0d with dropped elements): %0d requests in, %0d results out",
			sets_closed, overflow_sets, requests_in, results_out);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
